>>> rtl/output_dc_block_agc_limiter_top_macros.svh
// Assertion macros shared by the conditioner modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef OUTPUT_DC_BLOCK_AGC_LIMITER_TOP_MACROS_SVH
`define OUTPUT_DC_BLOCK_AGC_LIMITER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ODAGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ODAGC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ODAGC_ASSERT_IMP(lbl, ante, cons, msg)

`define ODAGC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/odagc_pkg.sv
package odagc_pkg;

    // Datapath geometry
    localparam int SAMPLE_WIDTH = 24;
    localparam int FRAC_BITS    = 16;
    localparam int COEFF_BITS   = 24;

    localparam int TARGET_W = FRAC_BITS + 1;
    localparam int OUT_W    = FRAC_BITS + 2;
    localparam int CFG_W    = (COEFF_BITS > TARGET_W) ? COEFF_BITS : TARGET_W;
    localparam int DIFF_W   = SAMPLE_WIDTH + 1;
    localparam int MUL_A_W  = DIFF_W;
    localparam int MUL_B_W  = (COEFF_BITS > TARGET_W) ? COEFF_BITS : TARGET_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int NUM_W    = SAMPLE_WIDTH + TARGET_W;
    localparam int QUO_W    = FRAC_BITS + 1;
    localparam int QCNT_W   = $clog2(QUO_W);

    // Unity in Q.FRAC_BITS at sample and quotient widths
    localparam logic [SAMPLE_WIDTH-1:0] ONE_Q   = SAMPLE_WIDTH'(1) << FRAC_BITS;
    localparam logic [QUO_W-1:0]        ONE_QUO = QUO_W'(1) << FRAC_BITS;

    // Register reset values
    localparam logic [COEFF_BITS-1:0] DC_COEFF_RST      = COEFF_BITS'(190);
    localparam logic [COEFF_BITS-1:0] ATTACK_COEFF_RST  = COEFF_BITS'(75917);
    localparam logic [COEFF_BITS-1:0] RELEASE_COEFF_RST = COEFF_BITS'(1902);
    localparam logic [TARGET_W-1:0]   TARGET_LEVEL_RST  = TARGET_W'(45875);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DC_COEFF      = 2'd0,
        CFG_ATTACK_COEFF  = 2'd1,
        CFG_RELEASE_COEFF = 2'd2,
        CFG_TARGET_LEVEL  = 2'd3
    } t_cfg_idx;

    // Divider status towards the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

endpackage

>>> rtl/odagc_ifs.sv
interface odagc_in_if;
    import odagc_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface odagc_out_if;
    import odagc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/odagc_div.sv
`include "output_dc_block_agc_limiter_top_macros.svh"

module odagc_div (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [odagc_pkg::NUM_W-1:0]              i_num,
    input  logic [odagc_pkg::SAMPLE_WIDTH-1:0]       i_den,
    output odagc_pkg::t_div_stat                     o_stat,
    output logic [odagc_pkg::QUO_W-1:0]              o_quo
);
    import odagc_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic                    r_sat,  n_sat;
    logic [QCNT_W-1:0]       r_cnt,  n_cnt;
    logic [SAMPLE_WIDTH-1:0] r_den,  n_den;
    logic [SAMPLE_WIDTH-1:0] r_rem,  n_rem;
    logic [QUO_W-1:0]        r_low,  n_low;
    logic [QUO_W-1:0]        r_quo,  n_quo;

    logic [DIFF_W-1:0]       trial;
    logic [DIFF_W-1:0]       trial_sub;
    logic                    trial_ge;
    logic                    will_sat;

    // Quotient of 2^QUO_W or more saturates anyway: detect it up front
    assign will_sat = i_num >= {i_den, {QUO_W{1'b0}}};

    // One restoring step: bring down the next numerator bit, subtract if it fits
    assign trial     = {r_rem, r_low[QUO_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign trial_ge  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quo  = r_quo;
        if (i_start) begin
            n_sat = will_sat;
            n_den = i_den;
            n_rem = i_num[NUM_W-1 -: SAMPLE_WIDTH];
            n_low = i_num[QUO_W-1:0];
            n_quo = '0;
            n_cnt = QCNT_W'(QUO_W - 1);
            if (will_sat) begin
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem = trial_ge ? trial_sub[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
            n_low = {r_low[QUO_W-2:0], 1'b0};
            n_quo = {r_quo[QUO_W-2:0], trial_ge};
            n_cnt = r_cnt - QCNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_sat  <= n_sat;
        end
        r_cnt <= n_cnt;
        r_den <= n_den;
        r_rem <= n_rem;
        r_low <= n_low;
        r_quo <= n_quo;
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = r_sat;
    assign o_quo       = r_quo;

    // Checks
    `ODAGC_ASSERT_IMP(a_no_restart, i_start, !r_busy, "divider restarted while busy")
    `ODAGC_ASSERT_NXT(a_done_pulse, r_done, !r_done, "divider done held over two cycles")
    `ODAGC_ASSERT_IMP(a_rem_below_den, r_busy, r_rem < r_den, "partial remainder reached divisor")

endmodule

>>> rtl/output_dc_block_agc_limiter_top.sv
// Channel     Dir  Payload                      Handshake
// i_smp       in   sample_in  (24b signed)      valid/ready
// o_smp       out  sample_out (18b signed Q1.16) valid/ready
// i_cfg_*     in   idx 2b, data 24b             write enable, no stall
//
// One sample at a time: the next sample is accepted only after the eight
// sequencer steps around the shared 25x24 multiplier, the 17 restoring steps
// of the divider and the done, output and idle states; a saturating quotient
// skips the divide steps.
// Synchronous active-low reset: registers to reset values, DC 0, envelope 1.0.
// A result waits in the output register; the next sample is taken meanwhile, and
// the sequencer stalls only when a second result is ready before the first leaves.
`include "output_dc_block_agc_limiter_top_macros.svh"

module output_dc_block_agc_limiter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    odagc_in_if.sink                         i_smp,
    odagc_out_if.source                      o_smp,
    input  logic                             i_cfg_we,
    input  odagc_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [odagc_pkg::CFG_W-1:0]      i_cfg_data
);
    import odagc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DC_MUL,
        S_DC_UPD,
        S_ENV_ABS,
        S_ENV_DIFF,
        S_ENV_MUL,
        S_ENV_UPD,
        S_GAIN_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    t_state                  r_state, n_state;

    // Configuration registers
    logic [COEFF_BITS-1:0]   r_dc_coeff,  n_dc_coeff;
    logic [COEFF_BITS-1:0]   r_att_coeff, n_att_coeff;
    logic [COEFF_BITS-1:0]   r_rel_coeff, n_rel_coeff;
    logic [TARGET_W-1:0]     r_target,    n_target;

    // Tracker state
    logic [SAMPLE_WIDTH-1:0] r_dc,  n_dc;
    logic [SAMPLE_WIDTH-1:0] r_env, n_env;

    // Working registers
    logic [SAMPLE_WIDTH-1:0] r_x,    n_x;
    logic [DIFF_W-1:0]       r_mag,  n_mag;
    logic                    r_dir,  n_dir;
    logic                    r_att,  n_att;
    logic [SAMPLE_WIDTH-1:0] r_a,    n_a;
    logic                    r_neg,  n_neg;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [QUO_W-1:0]        r_q,    n_q;
    logic                    r_ov,   n_ov;
    logic [OUT_W-1:0]        r_y,    n_y;

    // Shared multiplier operands
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       mul_p;

    logic [DIFF_W-1:0]       step;
    logic [DIFF_W-1:0]       in_diff;
    logic [DIFF_W-1:0]       dc_sum;
    logic [DIFF_W-1:0]       d_val;
    logic [DIFF_W-1:0]       d_abs;
    logic [DIFF_W-1:0]       env_sum;
    logic [QUO_W-1:0]        q_sat;
    logic                    out_free;

    t_div_stat               div_stat;
    logic [QUO_W-1:0]        div_quo;
    logic                    div_start;

    assign i_smp.ready      = (r_state == S_IDLE);
    assign o_smp.valid      = r_ov;
    assign o_smp.sample_out = r_y;

    assign out_free  = !r_ov || o_smp.ready;
    assign div_start = (r_state == S_DIV_START);

    // Operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_DC_MUL: begin
                mul_a = r_mag;
                mul_b = MUL_B_W'(r_dc_coeff);
            end
            S_ENV_MUL: begin
                mul_a = r_mag;
                mul_b = r_att ? MUL_B_W'(r_att_coeff) : MUL_B_W'(r_rel_coeff);
            end
            default: begin
                mul_a = {1'b0, r_a};
                mul_b = MUL_B_W'(r_target);
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign step  = r_prod[COEFF_BITS +: DIFF_W];

    // Signed differences in one extra bit
    assign in_diff = {i_smp.sample_in[SAMPLE_WIDTH-1], i_smp.sample_in}
                   - {r_dc[SAMPLE_WIDTH-1], r_dc};
    assign dc_sum  = r_dir ? ({r_dc[SAMPLE_WIDTH-1], r_dc} + step)
                           : ({r_dc[SAMPLE_WIDTH-1], r_dc} - step);
    assign d_val   = {r_x[SAMPLE_WIDTH-1], r_x} - {r_dc[SAMPLE_WIDTH-1], r_dc};
    assign d_abs   = d_val[DIFF_W-1] ? (DIFF_W'(0) - d_val) : d_val;
    assign env_sum = r_dir ? ({1'b0, r_env} + step) : ({1'b0, r_env} - step);

    // Clamp the quotient to unity
    assign q_sat = (div_stat.sat || (div_quo > ONE_QUO)) ? ONE_QUO : div_quo;

    always_comb begin
        n_state     = r_state;
        n_dc_coeff  = r_dc_coeff;
        n_att_coeff = r_att_coeff;
        n_rel_coeff = r_rel_coeff;
        n_target    = r_target;
        n_dc        = r_dc;
        n_env       = r_env;
        n_x         = r_x;
        n_mag       = r_mag;
        n_dir       = r_dir;
        n_att       = r_att;
        n_a         = r_a;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_q         = r_q;
        n_ov        = r_ov;
        n_y         = r_y;

        // Register writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DC_COEFF:      n_dc_coeff  = i_cfg_data[COEFF_BITS-1:0];
                CFG_ATTACK_COEFF:  n_att_coeff = i_cfg_data[COEFF_BITS-1:0];
                CFG_RELEASE_COEFF: n_rel_coeff = i_cfg_data[COEFF_BITS-1:0];
                CFG_TARGET_LEVEL:  n_target    = i_cfg_data[TARGET_W-1:0];
            endcase
        end

        // Drop the result once taken
        if (r_ov && o_smp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    n_x     = i_smp.sample_in;
                    n_dir   = !in_diff[DIFF_W-1];
                    n_mag   = in_diff[DIFF_W-1] ? (DIFF_W'(0) - in_diff) : in_diff;
                    n_state = S_DC_MUL;
                end
            end
            S_DC_MUL: begin
                n_prod  = mul_p;
                n_state = S_DC_UPD;
            end
            S_DC_UPD: begin
                n_dc    = dc_sum[SAMPLE_WIDTH-1:0];
                n_state = S_ENV_ABS;
            end
            S_ENV_ABS: begin
                n_neg   = d_val[DIFF_W-1];
                n_a     = d_abs[SAMPLE_WIDTH-1:0];
                n_state = S_ENV_DIFF;
            end
            S_ENV_DIFF: begin
                n_dir   = r_a >= r_env;
                n_att   = r_a > r_env;
                n_mag   = (r_a >= r_env) ? ({1'b0, r_a} - {1'b0, r_env})
                                         : ({1'b0, r_env} - {1'b0, r_a});
                n_state = S_ENV_MUL;
            end
            S_ENV_MUL: begin
                n_prod  = mul_p;
                n_state = S_ENV_UPD;
            end
            S_ENV_UPD: begin
                priority if (env_sum[DIFF_W-1]) begin
                    n_env = '1;
                end else if (env_sum[SAMPLE_WIDTH-1:0] < ONE_Q) begin
                    n_env = ONE_Q;
                end else begin
                    n_env = env_sum[SAMPLE_WIDTH-1:0];
                end
                n_state = S_GAIN_MUL;
            end
            S_GAIN_MUL: begin
                n_prod  = mul_p;
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_q     = q_sat;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_y     = r_neg ? (OUT_W'(0) - OUT_W'(r_q)) : OUT_W'(r_q);
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dc_coeff  <= DC_COEFF_RST;
            r_att_coeff <= ATTACK_COEFF_RST;
            r_rel_coeff <= RELEASE_COEFF_RST;
            r_target    <= TARGET_LEVEL_RST;
            r_dc        <= '0;
            r_env       <= ONE_Q;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dc_coeff  <= n_dc_coeff;
            r_att_coeff <= n_att_coeff;
            r_rel_coeff <= n_rel_coeff;
            r_target    <= n_target;
            r_dc        <= n_dc;
            r_env       <= n_env;
            r_ov        <= n_ov;
        end
        r_x    <= n_x;
        r_mag  <= n_mag;
        r_dir  <= n_dir;
        r_att  <= n_att;
        r_a    <= n_a;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_y    <= n_y;
    end

    // Divide the gained magnitude by the envelope
    odagc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod[NUM_W-1:0]),
        .i_den   (r_env),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // Checks
    `ODAGC_ASSERT_NXT(a_one_at_a_time, i_smp.valid && i_smp.ready, !i_smp.ready, "sample taken while busy")
    `ODAGC_ASSERT_IMP(a_env_floor, 1'b1, r_env >= ONE_Q, "envelope fell below unity")
    `ODAGC_ASSERT_IMP(a_out_bound, r_ov, (r_y == OUT_W'(ONE_QUO)) || (r_y == (OUT_W'(0) - OUT_W'(ONE_QUO))) || (r_y[OUT_W-1] == r_y[OUT_W-2]), "result beyond unity")
    `ODAGC_ASSERT_IMP(a_done_in_wait, div_stat.done, r_state == S_DIV_WAIT, "divider finished outside wait")

endmodule

>>> tb/sv/output_dc_block_agc_limiter_top_test.sv
module output_dc_block_agc_limiter_top_test;
    import odagc_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint SMP_MIN = -(longint'(1) << (SAMPLE_WIDTH - 1));
    localparam longint SMP_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint UNITY = longint'(1) << FRAC_BITS;
    localparam longint ENV_CEIL = (longint'(1) << SAMPLE_WIDTH) - 1;
    localparam int     PHASES = 9;
    localparam int     PHASE_ITEMS = 50;

    typedef enum bit {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        t_cfg_idx                       idx;
        logic [CFG_W-1:0]               data;
        logic signed [SAMPLE_WIDTH-1:0] x;
        bit                             known;
        logic signed [OUT_W-1:0]        y;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    odagc_in_if  smp_in ();
    odagc_out_if smp_out ();

    // Conditioner state and register copies
    logic [COEFF_BITS-1:0] k_dc;
    logic [COEFF_BITS-1:0] k_attack;
    logic [COEFF_BITS-1:0] k_release;
    logic [TARGET_W-1:0]   gain_target;
    longint                dc_track;
    longint                env_track;

    logic signed [OUT_W-1:0] expected_out [$];
    int                      mismatches = 0;
    int                      src_calm = 0;
    int                      sink_calm = 0;
    int                      cycle_count = 0;

    output_dc_block_agc_limiter_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_in),
        .o_smp      (smp_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Move v toward t by a truncated fraction of the distance
    function automatic longint step_toward(longint v, longint t, longint unsigned c);
        longint unsigned span;
        if (t >= v) begin
            span = longint'(t - v);
            return v + longint'((span * c) >> COEFF_BITS);
        end
        span = longint'(v - t);
        return v - longint'((span * c) >> COEFF_BITS);
    endfunction

    // DC removal, envelope tracking and limited gain for one sample
    function automatic logic signed [OUT_W-1:0] condition_sample(
        logic signed [SAMPLE_WIDTH-1:0] s
    );
        longint          x;
        longint          d;
        longint          e;
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned k;
        x = s;
        dc_track = step_toward(dc_track, x, k_dc);
        d = x - dc_track;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        k = (longint'(mag) > env_track) ? k_attack : k_release;
        e = step_toward(env_track, longint'(mag), k);
        if (e < UNITY)
            e = UNITY;
        if (e > ENV_CEIL)
            e = ENV_CEIL;
        env_track = e;
        quo = (mag * longint'(gain_target)) / longint'(e);
        if (quo > UNITY)
            quo = UNITY;
        return (d < 0) ? OUT_W'(-longint'(quo)) : OUT_W'(longint'(quo));
    endfunction

    // Idle length for one transaction, with stretches of back-to-back traffic
    function automatic int draw_gap(ref int calm_left);
        if (calm_left == 0 && $urandom_range(0, 15) == 0)
            calm_left = $urandom_range(5, 30);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting(bit is_target);
        if (is_target) begin
            case ($urandom_range(0, 4))
                0: return '0;
                1: return CFG_W'(UNITY);
                2: return CFG_W'($urandom_range(20000, 65536));
                3: return CFG_W'($urandom_range(0, 65536));
                default: return CFG_W'($urandom());
            endcase
        end
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(0, 4095));
            3: return CFG_W'($urandom_range(0, 262143));
            4: return CFG_W'($urandom_range(1000, 100000));
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic t_row cfg_row(t_cfg_idx idx, longint data);
        t_row r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.data  = CFG_W'(data);
        r.x     = '0;
        r.known = 1'b0;
        r.y     = '0;
        return r;
    endfunction

    function automatic t_row smp_row(longint x, bit known, longint y);
        t_row r;
        r.kind  = ROW_SAMPLE;
        r.idx   = CFG_DC_COEFF;
        r.data  = '0;
        r.x     = SAMPLE_WIDTH'(x);
        r.known = known;
        r.y     = OUT_W'(y);
        return r;
    endfunction

    // Write one register once all outstanding results are back
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        smp_in.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DC_COEFF:      k_dc = data[COEFF_BITS-1:0];
            CFG_ATTACK_COEFF:  k_attack = data[COEFF_BITS-1:0];
            CFG_RELEASE_COEFF: k_release = data[COEFF_BITS-1:0];
            CFG_TARGET_LEVEL:  gain_target = data[TARGET_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample and queue its expected result on acceptance
    task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] x, bit known,
                               logic signed [OUT_W-1:0] y);
        int                      gap;
        logic signed [OUT_W-1:0] predicted;
        gap = draw_gap(src_calm);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            smp_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_in.valid     <= 1'b1;
        smp_in.sample_in <= x;
        do @(posedge i_clk); while (smp_in.ready !== 1'b1);
        predicted = condition_sample(x);
        expected_out = {expected_out, (known ? y : predicted)};
    endtask

    // Result sink: stall at random and check each transaction in order
    initial begin
        int                      gap;
        logic signed [OUT_W-1:0] want;
        smp_out.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap(sink_calm);
            if (gap != 0) begin
                smp_out.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            smp_out.ready <= 1'b1;
            do @(posedge i_clk); while (smp_out.valid !== 1'b1);
            if (expected_out.size() == 0) begin
                $error("sample_out: expected no result, actual %0d", smp_out.sample_out);
                mismatches++;
            end else begin
                want = expected_out.pop_front();
                if (smp_out.sample_out !== want) begin
                    $error("sample_out: expected %0d, actual %0d", want, smp_out.sample_out);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_row                           plan [$];
        int                             level;
        longint                         bias;
        longint                         v;
        logic signed [SAMPLE_WIDTH-1:0] x;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_DC_COEFF;
        i_cfg_data       <= '0;
        smp_in.valid     <= 1'b0;
        smp_in.sample_in <= '0;

        k_dc        = DC_COEFF_RST;
        k_attack    = ATTACK_COEFF_RST;
        k_release   = RELEASE_COEFF_RST;
        gain_target = TARGET_LEVEL_RST;
        dc_track    = 0;
        env_track   = UNITY;

        // Reset settings: silence, full-scale swings, tiny and ordinary levels
        plan = {plan, smp_row(0, 1, 0)};
        plan = {plan, smp_row(SMP_MAX, 1, UNITY)};
        plan = {plan, smp_row(SMP_MIN, 1, -UNITY)};
        plan = {plan, smp_row(1, 0, 0)};
        plan = {plan, smp_row(-1, 0, 0)};
        plan = {plan, smp_row(65536, 0, 0)};
        plan = {plan, smp_row(-32768, 0, 0)};
        plan = {plan, smp_row(300, 0, 0)};
        // Zero target mutes everything
        plan = {plan, cfg_row(CFG_TARGET_LEVEL, 0)};
        plan = {plan, smp_row(5000000, 1, 0)};
        plan = {plan, smp_row(-5000000, 1, 0)};
        // Near-full steps: DC lands within one LSB of the input
        plan = {plan, cfg_row(CFG_TARGET_LEVEL, UNITY)};
        plan = {plan, cfg_row(CFG_DC_COEFF, 24'hFFFFFF)};
        plan = {plan, cfg_row(CFG_ATTACK_COEFF, 24'hFFFFFF)};
        plan = {plan, cfg_row(CFG_RELEASE_COEFF, 24'hFFFFFF)};
        plan = {plan, smp_row(SMP_MIN, 0, 0)};
        plan = {plan, smp_row(SMP_MIN, 0, 0)};
        // Frozen DC at the bottom rail drives the envelope towards its ceiling
        plan = {plan, cfg_row(CFG_DC_COEFF, 0)};
        plan = {plan, smp_row(SMP_MAX, 0, 0)};
        plan = {plan, smp_row(SMP_MAX, 0, 0)};
        // Frozen envelope
        plan = {plan, cfg_row(CFG_ATTACK_COEFF, 0)};
        plan = {plan, cfg_row(CFG_RELEASE_COEFF, 0)};
        plan = {plan, smp_row(100, 0, 0)};
        plan = {plan, smp_row(-7000000, 0, 0)};
        // Instant release towards the unity floor
        plan = {plan, cfg_row(CFG_RELEASE_COEFF, 24'hFFFFFF)};
        plan = {plan, cfg_row(CFG_DC_COEFF, 24'hFFFFFF)};
        plan = {plan, smp_row(0, 0, 0)};
        plan = {plan, smp_row(0, 0, 0)};
        // Oversized target, bounded by the output limiter
        plan = {plan, cfg_row(CFG_TARGET_LEVEL, 17'h1FFFF)};
        plan = {plan, smp_row(40000, 0, 0)};
        plan = {plan, smp_row(-40000, 0, 0)};
        // Back to reset settings
        plan = {plan, cfg_row(CFG_DC_COEFF, DC_COEFF_RST)};
        plan = {plan, cfg_row(CFG_ATTACK_COEFF, ATTACK_COEFF_RST)};
        plan = {plan, cfg_row(CFG_RELEASE_COEFF, RELEASE_COEFF_RST)};
        plan = {plan, cfg_row(CFG_TARGET_LEVEL, TARGET_LEVEL_RST)};
        plan = {plan, smp_row(1234, 0, 0)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_sample(plan[i].x, plan[i].known, plan[i].y);
        end

        // Random phases: fresh settings, then audio-like samples around an offset
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                write_reg(CFG_DC_COEFF, DC_COEFF_RST);
            end else begin
                write_reg(CFG_DC_COEFF, pick_setting(1'b0));
                write_reg(CFG_ATTACK_COEFF, pick_setting(1'b0));
                write_reg(CFG_RELEASE_COEFF, pick_setting(1'b0));
                write_reg(CFG_TARGET_LEVEL, pick_setting(1'b1));
            end
            level = $urandom_range(8, SAMPLE_WIDTH - 1);
            bias  = longint'($urandom_range(0, 1 << 20)) - (longint'(1) << 19);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    x = SAMPLE_WIDTH'($urandom());
                end else begin
                    v = bias + longint'($urandom_range(0, (1 << (level + 1)) - 1))
                        - (longint'(1) << level);
                    if (v > SMP_MAX)
                        v = SMP_MAX;
                    if (v < SMP_MIN)
                        v = SMP_MIN;
                    x = SAMPLE_WIDTH'(v);
                end
                send_sample(x, 1'b0, '0);
            end
        end

        // Drain outstanding results, then hold a little longer for strays
        smp_in.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
